// ===== design/mwmn_pkg.sv =====
`default_nettype none

package mwmn_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS = 14;
    localparam int CMD_W     = 16;
    localparam int LANES     = 4;
    localparam int SUM_W     = 18;                 // f +/- c +/- s without wrap
    localparam int MAG_W     = 17;                 // largest |sum| is 98304
    localparam int REM_W     = MAG_W + 1;          // remainder stays below 2*max
    localparam int QUO_W     = FRAC_BITS + 1;      // quotient never exceeds ONE
    localparam int SEL_W     = (QUO_W > MAG_W) ? QUO_W : MAG_W;

    localparam logic [SEL_W-1:0] ONE_SEL = SEL_W'(1) << FRAC_BITS;
    localparam logic [QUO_W-1:0] ONE_QUO = QUO_W'(1) << FRAC_BITS;

    // Front-left and back-left wheels are driven with inverted sign
    localparam logic [LANES-1:0] LANE_NEG = LANES'(4'b0101);

    // Output saturation limits
    localparam logic [SEL_W-1:0] LIM_POS = SEL_W'(32767);
    localparam logic [SEL_W-1:0] LIM_NEG = SEL_W'(32768);
    localparam logic [CMD_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [CMD_W-1:0] SAT_NEG = 16'h8000;

    // Input word, forward command in the lowest bits
    typedef struct packed {
        logic [CMD_W-1:0] rotate_cmd;
        logic [CMD_W-1:0] strafe_cmd;
        logic [CMD_W-1:0] forward_cmd;
    } t_cmd;

    typedef struct packed {
        logic [LANES-1:0][SUM_W-1:0] sum;
    } t_mix;

    typedef struct packed {
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][MAG_W-1:0] mag;
    } t_mag;

    typedef struct packed {
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [LANES-1:0][REM_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] quo;
        logic [MAG_W-1:0]            max;
        logic                        norm;
    } t_div;

    // Output word, lane 0 (front-left) in the lowest bits
    typedef struct packed {
        logic [LANES-1:0][CMD_W-1:0] drive;
    } t_drv;

endpackage

`default_nettype wire

// ===== design/mwmn_mix.sv =====
`default_nettype none

// Two stages: wheel sums, then sign and magnitude per wheel.
module mwmn_mix (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mwmn_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mwmn_pkg::t_mag      o_mag
);

    logic                                                r_v1;
    logic                                                r_v2;
    mwmn_pkg::t_mix                                      r_mix;
    mwmn_pkg::t_mix                                      n_mix;
    mwmn_pkg::t_mag                                      r_mag;
    mwmn_pkg::t_mag                                      n_mag;
    logic                                                ld1;
    logic                                                ld2;
    logic signed [mwmn_pkg::SUM_W-1:0]                   f;
    logic signed [mwmn_pkg::SUM_W-1:0]                   s;
    logic signed [mwmn_pkg::SUM_W-1:0]                   c;
    logic [mwmn_pkg::LANES-1:0][mwmn_pkg::SUM_W-1:0]     n_abs;

    assign ld2     = !r_v2 || i_ready;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1;
    assign o_valid = r_v2;
    assign o_mag   = r_mag;

    always_comb begin
        f = mwmn_pkg::SUM_W'($signed(i_cmd.forward_cmd));
        s = mwmn_pkg::SUM_W'($signed(i_cmd.strafe_cmd));
        c = mwmn_pkg::SUM_W'($signed(i_cmd.rotate_cmd));
        n_mix.sum[0] = f + c - s;
        n_mix.sum[1] = f - c - s;
        n_mix.sum[2] = f + c + s;
        n_mix.sum[3] = f - c + s;
    end

    always_comb begin
        for (int k = 0; k < mwmn_pkg::LANES; k++) begin
            n_mag.neg[k] = r_mix.sum[k][mwmn_pkg::SUM_W-1];
            n_abs[k]     = n_mag.neg[k] ? (~r_mix.sum[k] + mwmn_pkg::SUM_W'(1))
                                        : r_mix.sum[k];
            n_mag.mag[k] = n_abs[k][mwmn_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_valid;
            if (ld2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1 && i_valid) r_mix <= n_mix;
        if (ld2 && r_v1)    r_mag <= n_mag;
    end

endmodule

`default_nettype wire

// ===== design/mwmn_max.sv =====
`default_nettype none

// Largest magnitude, normalize decision and divider seed.
module mwmn_max (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mwmn_pkg::t_mag i_mag,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mwmn_pkg::t_div      o_div
);

    logic                          r_valid;
    mwmn_pkg::t_div                r_div;
    mwmn_pkg::t_div                n_div;
    logic                          ld;
    logic [mwmn_pkg::MAG_W-1:0]    m01;
    logic [mwmn_pkg::MAG_W-1:0]    m23;

    assign ld      = !r_valid || i_ready;
    assign o_ready = ld;
    assign o_valid = r_valid;
    assign o_div   = r_div;

    always_comb begin
        m01 = (i_mag.mag[0] > i_mag.mag[1]) ? i_mag.mag[0] : i_mag.mag[1];
        m23 = (i_mag.mag[2] > i_mag.mag[3]) ? i_mag.mag[2] : i_mag.mag[3];
        n_div.max  = (m01 > m23) ? m01 : m23;
        n_div.norm = mwmn_pkg::SEL_W'(n_div.max) >= mwmn_pkg::ONE_SEL;
        n_div.neg  = i_mag.neg;
        n_div.mag  = i_mag.mag;
        for (int k = 0; k < mwmn_pkg::LANES; k++) begin
            n_div.rem[k] = mwmn_pkg::REM_W'(i_mag.mag[k]);
            n_div.quo[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld && i_valid) r_div <= n_div;
    end

    a_max_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_div.max >= r_div.mag[0]) && (r_div.max >= r_div.mag[1]) &&
                    (r_div.max >= r_div.mag[2]) && (r_div.max >= r_div.mag[3]))
        else $error("max stage: maximum below a wheel magnitude");

endmodule

`default_nettype wire

// ===== design/mwmn_div_step.sv =====
`default_nettype none

// One restoring-division step per lane: one quotient bit a stage.
module mwmn_div_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mwmn_pkg::t_div i_div,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mwmn_pkg::t_div      o_div
);

    logic                                              r_valid;
    mwmn_pkg::t_div                                    r_div;
    mwmn_pkg::t_div                                    n_div;
    logic                                              ld;
    logic [mwmn_pkg::LANES-1:0]                        ge;
    logic [mwmn_pkg::LANES-1:0][mwmn_pkg::REM_W-1:0]   diff;

    assign ld      = !r_valid || i_ready;
    assign o_ready = ld;
    assign o_valid = r_valid;
    assign o_div   = r_div;

    always_comb begin
        n_div = i_div;
        for (int k = 0; k < mwmn_pkg::LANES; k++) begin
            ge[k]   = i_div.rem[k] >= mwmn_pkg::REM_W'(i_div.max);
            diff[k] = ge[k] ? (i_div.rem[k] - mwmn_pkg::REM_W'(i_div.max)) : i_div.rem[k];
            // diff is below max, so the shift cannot overflow
            n_div.rem[k] = {diff[k][mwmn_pkg::REM_W-2:0], 1'b0};
            n_div.quo[k] = {i_div.quo[k][mwmn_pkg::QUO_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld && i_valid) r_div <= n_div;
    end

endmodule

`default_nettype wire

// ===== design/mwmn_out.sv =====
`default_nettype none

// Select scaled or raw speed, apply wheel sign, saturate, register output word.
module mwmn_out (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mwmn_pkg::t_div i_div,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mwmn_pkg::t_drv      o_drv
);

    logic                                              r_valid;
    mwmn_pkg::t_drv                                    r_drv;
    mwmn_pkg::t_drv                                    n_drv;
    logic                                              ld;
    logic [mwmn_pkg::LANES-1:0][mwmn_pkg::SEL_W-1:0]   sel;
    logic [mwmn_pkg::LANES-1:0]                        neg_o;

    assign ld      = !r_valid || i_ready;
    assign o_ready = ld;
    assign o_valid = r_valid;
    assign o_drv   = r_drv;

    always_comb begin
        for (int k = 0; k < mwmn_pkg::LANES; k++) begin
            sel[k]   = i_div.norm ? mwmn_pkg::SEL_W'(i_div.quo[k])
                                  : mwmn_pkg::SEL_W'(i_div.mag[k]);
            neg_o[k] = i_div.neg[k] ^ mwmn_pkg::LANE_NEG[k];
            if (neg_o[k]) begin
                n_drv.drive[k] = (sel[k] >= mwmn_pkg::LIM_NEG) ? mwmn_pkg::SAT_NEG
                               : (~sel[k][mwmn_pkg::CMD_W-1:0] + mwmn_pkg::CMD_W'(1));
            end else begin
                n_drv.drive[k] = (sel[k] > mwmn_pkg::LIM_POS) ? mwmn_pkg::SAT_POS
                               : sel[k][mwmn_pkg::CMD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld && i_valid) r_drv <= n_drv;
    end

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_div.norm) |->
            (i_div.quo[0] <= mwmn_pkg::ONE_QUO) && (i_div.quo[1] <= mwmn_pkg::ONE_QUO) &&
            (i_div.quo[2] <= mwmn_pkg::ONE_QUO) && (i_div.quo[3] <= mwmn_pkg::ONE_QUO))
        else $error("out stage: scaled speed above one");

    a_max_is_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_div.norm) |->
            (i_div.quo[0] == mwmn_pkg::ONE_QUO) || (i_div.quo[1] == mwmn_pkg::ONE_QUO) ||
            (i_div.quo[2] == mwmn_pkg::ONE_QUO) || (i_div.quo[3] == mwmn_pkg::ONE_QUO))
        else $error("out stage: no wheel scaled to exactly one");

endmodule

`default_nettype wire

// ===== design/mecanum_wheel_mix_normalize.sv =====
`default_nettype none

// Channel   Dir  Width  Word contents (lowest bits first)
// s_axis    in   48     forward_cmd, strafe_cmd, rotate_cmd (signed Q1.14 each)
// m_axis    out  64     FL, FR, BL, BR wheel drive speeds (signed Q1.14 each)
//
// One command word enters per clock while s_axis_tready is high; a stalled
// output word holds the pipeline. The restoring divider yields one quotient
// bit per stage. Synchronous active-low reset clears every stage valid bit; the
// data registers are not reset. A stage loads when it is empty or its
// successor loads, so bubbles close up behind a stalled output word.
module mecanum_wheel_mix_normalize (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [47:0]                 s_axis_tdata,  // fwd, strafe, rotate
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [63:0]                      m_axis_tdata   // FL, FR, BL, BR
);

    mwmn_pkg::t_cmd                 cmd;
    mwmn_pkg::t_mag                 mix_mag;
    mwmn_pkg::t_drv                 drv;
    logic                           mix_valid;
    logic                           mix_ready;
    mwmn_pkg::t_div                 div_d [mwmn_pkg::QUO_W+1];
    logic [mwmn_pkg::QUO_W:0]       div_v;
    logic [mwmn_pkg::QUO_W:0]       div_rdy;

    assign cmd          = s_axis_tdata;
    assign m_axis_tdata = drv;

    // Wheel sums and magnitudes
    mwmn_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (cmd),
        .o_valid (mix_valid),
        .i_ready (mix_ready),
        .o_mag   (mix_mag)
    );

    // Largest magnitude and divider seed
    mwmn_max u_max (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .o_ready (mix_ready),
        .i_mag   (mix_mag),
        .o_valid (div_v[0]),
        .i_ready (div_rdy[0]),
        .o_div   (div_d[0])
    );

    // Divider chain: speed * ONE / max, one quotient bit per stage
    for (genvar g = 0; g < mwmn_pkg::QUO_W; g++) begin : g_div
        mwmn_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_v[g]),
            .o_ready (div_rdy[g]),
            .i_div   (div_d[g]),
            .o_valid (div_v[g+1]),
            .i_ready (div_rdy[g+1]),
            .o_div   (div_d[g+1])
        );
    end

    // Sign, bypass when below one, saturate, output register
    mwmn_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_v[mwmn_pkg::QUO_W]),
        .o_ready (div_rdy[mwmn_pkg::QUO_W]),
        .i_div   (div_d[mwmn_pkg::QUO_W]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_drv   (drv)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("top: output word valid right after reset");

endmodule

`default_nettype wire
